// ===== rtl/core/gtpu_pkg.sv =====
`timescale 1ns / 1ps
package gtpu_pkg;

    localparam int HOLD_BEATS_DEF = 40;
    localparam int DQ_DEPTH       = 4;

    localparam logic [15:0] UDP_PORT_DEF = 16'd2152;
    localparam logic [7:0]  MSG_TYPE_DEF = 8'd255;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [7:0]  IP_UDP   = 8'd17;
    localparam logic [3:0]  VER_IPV4 = 4'd4;

    localparam logic REG_UDP_PORT = 1'b0;
    localparam logic REG_MSG_TYPE = 1'b1;

    localparam logic [2:0] ST_STRIPPED = 3'd0;
    localparam logic [2:0] ST_NOT_IP   = 3'd1;
    localparam logic [2:0] ST_NOT_UDP  = 3'd2;
    localparam logic [2:0] ST_BAD_PORT = 3'd3;
    localparam logic [2:0] ST_NOT_GTPU = 3'd4;
    localparam logic [2:0] ST_SHORT    = 3'd5;

    typedef struct packed {
        logic [15:0] data;
        logic        odd;
        logic        last;
    } t_beat;

    typedef struct packed {
        logic [2:0] status;
        logic       inner_v4;
        logic       vlan;
        logic [5:0] dbeat;
    } t_dec;

endpackage

// ===== rtl/core/gtpu_front.sv =====
`timescale 1ns / 1ps
module gtpu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [15:0]        i_data,
    input  logic [1:0]         i_bytes,
    input  logic               i_last,
    input  logic [15:0]        i_udp_port,
    input  logic [7:0]         i_msg_type,
    output logic               o_beat_push,
    output gtpu_pkg::t_beat    o_beat,
    output logic               o_dec_push,
    output gtpu_pkg::t_dec     o_dec
);

    typedef enum logic [2:0] {
        CK_ET, CK_ET2, CK_VER, CK_PROTO, CK_PORT, CK_MSG, CK_INNER, CK_DONE
    } t_chk;

    t_chk       r_chk, n_chk;
    logic [5:0] r_idx;
    logic       r_vlan, n_vlan;
    logic       r_v6, n_v6;

    logic       odd;
    logic [5:0] tgt;
    logic [5:0] vo;
    logic       fail;
    logic       pass_all;
    logic [2:0] fail_st;

    assign odd = i_last && (i_bytes == 2'd1);
    assign vo  = r_vlan ? 6'd2 : 6'd0;

    always_comb begin
        case (r_chk)
            CK_ET:    tgt = 6'd6;
            CK_ET2:   tgt = 6'd8;
            CK_VER:   tgt = 6'd7 + vo;
            CK_PROTO: tgt = (r_v6 ? 6'd10 : 6'd11) + vo;
            CK_PORT:  tgt = (r_v6 ? 6'd28 : 6'd18) + vo;
            CK_MSG:   tgt = (r_v6 ? 6'd31 : 6'd21) + vo;
            CK_INNER: tgt = (r_v6 ? 6'd35 : 6'd25) + vo;
            default:  tgt = 6'd63;
        endcase
    end

    // one check per beat; a missing low byte leaves the frame undecided
    always_comb begin
        n_chk    = r_chk;
        n_vlan   = r_vlan;
        n_v6     = r_v6;
        fail     = 1'b0;
        pass_all = 1'b0;
        fail_st  = gtpu_pkg::ST_STRIPPED;
        if (r_chk != CK_DONE && r_idx == tgt) begin
            case (r_chk)
                CK_ET: begin
                    if (!odd) begin
                        if (i_data == gtpu_pkg::ETH_VLAN) begin
                            n_vlan = 1'b1;
                            n_chk  = CK_ET2;
                        end else if (i_data == gtpu_pkg::ETH_IPV4 ||
                                     i_data == gtpu_pkg::ETH_IPV6) begin
                            n_chk = CK_VER;
                        end else begin
                            fail    = 1'b1;
                            fail_st = gtpu_pkg::ST_NOT_IP;
                        end
                    end
                end
                CK_ET2: begin
                    if (!odd) begin
                        if (i_data == gtpu_pkg::ETH_IPV4 || i_data == gtpu_pkg::ETH_IPV6) begin
                            n_chk = CK_VER;
                        end else begin
                            fail    = 1'b1;
                            fail_st = gtpu_pkg::ST_NOT_IP;
                        end
                    end
                end
                CK_VER: begin
                    n_v6  = (i_data[15:12] != gtpu_pkg::VER_IPV4);
                    n_chk = CK_PROTO;
                end
                CK_PROTO: begin
                    if (r_v6 || !odd) begin
                        if ((r_v6 ? i_data[15:8] : i_data[7:0]) == gtpu_pkg::IP_UDP) begin
                            n_chk = CK_PORT;
                        end else begin
                            fail    = 1'b1;
                            fail_st = gtpu_pkg::ST_NOT_UDP;
                        end
                    end
                end
                CK_PORT: begin
                    if (!odd) begin
                        if (i_data == i_udp_port) begin
                            n_chk = CK_MSG;
                        end else begin
                            fail    = 1'b1;
                            fail_st = gtpu_pkg::ST_BAD_PORT;
                        end
                    end
                end
                CK_MSG: begin
                    if (!odd) begin
                        if (i_data[7:0] == i_msg_type) begin
                            n_chk = CK_INNER;
                        end else begin
                            fail    = 1'b1;
                            fail_st = gtpu_pkg::ST_NOT_GTPU;
                        end
                    end
                end
                CK_INNER: begin
                    pass_all = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_beat_push = i_accept;
    assign o_beat.data = i_data;
    assign o_beat.odd  = odd;
    assign o_beat.last = i_last;

    assign o_dec_push      = i_accept && (fail || pass_all || (i_last && r_chk != CK_DONE));
    assign o_dec.status    = fail ? fail_st : (pass_all ? gtpu_pkg::ST_STRIPPED
                                                        : gtpu_pkg::ST_SHORT);
    assign o_dec.inner_v4  = (i_data[15:12] == gtpu_pkg::VER_IPV4);
    assign o_dec.vlan      = r_vlan;
    assign o_dec.dbeat     = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk  <= CK_ET;
            r_idx  <= '0;
            r_vlan <= 1'b0;
            r_v6   <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_chk  <= CK_ET;
                r_idx  <= '0;
                r_vlan <= 1'b0;
                r_v6   <= 1'b0;
            end else begin
                r_chk  <= (fail || pass_all) ? CK_DONE : n_chk;
                r_idx  <= (r_idx == 6'd63) ? r_idx : r_idx + 6'd1;
                r_vlan <= n_vlan;
                r_v6   <= n_v6;
            end
        end
    end

endmodule

// ===== rtl/core/gtpu_queue.sv =====
`timescale 1ns / 1ps
module gtpu_queue #(
    parameter int HOLD_BEATS = gtpu_pkg::HOLD_BEATS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat_push,
    input  gtpu_pkg::t_beat  i_beat,
    input  logic             i_beat_pop,
    output gtpu_pkg::t_beat  o_beat,
    output logic             o_beat_empty,
    output logic             o_beat_full,
    input  logic             i_dec_push,
    input  gtpu_pkg::t_dec   i_dec,
    input  logic             i_dec_pop,
    output gtpu_pkg::t_dec   o_dec,
    output logic             o_dec_empty,
    output logic             o_dec_full
);

    localparam int QDEPTH = HOLD_BEATS + 1;
    localparam int PW     = $clog2(QDEPTH);
    localparam int CW     = $clog2(QDEPTH + 1);
    localparam int DPW    = $clog2(gtpu_pkg::DQ_DEPTH);
    localparam int DCW    = $clog2(gtpu_pkg::DQ_DEPTH + 1);

    gtpu_pkg::t_beat r_mem [QDEPTH];
    gtpu_pkg::t_beat r_rd;
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    gtpu_pkg::t_dec  r_dq [gtpu_pkg::DQ_DEPTH];
    logic [DPW-1:0]  r_dwp, r_drp;
    logic [DCW-1:0]  r_dcnt;

    assign o_beat       = r_rd;
    assign o_beat_empty = (r_cnt == '0);
    assign o_beat_full  = (r_cnt == CW'(QDEPTH));
    assign o_dec        = r_dq[r_drp];
    assign o_dec_empty  = (r_dcnt == '0);
    assign o_dec_full   = (r_dcnt == DCW'(gtpu_pkg::DQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_beat_push) begin
            r_mem[r_wp] <= i_beat;
        end
        if (i_beat_pop) begin
            r_rd <= r_mem[r_rp];
        end
        if (i_dec_push) begin
            r_dq[r_dwp] <= i_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_dwp  <= '0;
            r_drp  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_beat_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_beat_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_beat_push && !i_beat_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_beat_push && i_beat_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_dec_push) begin
                r_dwp <= r_dwp + DPW'(1);
            end
            if (i_dec_pop) begin
                r_drp <= r_drp + DPW'(1);
            end
            if (i_dec_push && !i_dec_pop) begin
                r_dcnt <= r_dcnt + DCW'(1);
            end else if (!i_dec_push && i_dec_pop) begin
                r_dcnt <= r_dcnt - DCW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/gtpu_back.sv =====
`timescale 1ns / 1ps
module gtpu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gtpu_pkg::t_beat  i_beat,
    input  logic             i_beat_empty,
    output logic             o_beat_pop,
    input  gtpu_pkg::t_dec   i_dec,
    input  logic             i_dec_empty,
    output logic             o_dec_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [15:0]      o_data,
    output logic [1:0]       o_bytes,
    output logic             o_last,
    output logic [2:0]       o_status
);

    logic        r_s1_valid;
    logic [5:0]  r_cnt;
    logic        r_o_valid;
    logic [15:0] r_o_data;
    logic [1:0]  r_o_bytes;
    logic        r_o_last;
    logic [2:0]  r_o_status;

    logic        strip;
    logic [5:0]  rep;
    logic        drop;
    logic        out_free;
    logic        s1_move;

    assign strip    = (i_dec.status == gtpu_pkg::ST_STRIPPED);
    assign rep      = i_dec.vlan ? 6'd8 : 6'd6;
    // outer headers sit between the rewritten ethertype and the decision beat
    assign drop     = strip && (r_cnt > rep) && (r_cnt < i_dec.dbeat);
    assign out_free = !r_o_valid || i_ready;
    assign s1_move  = r_s1_valid && !i_dec_empty && (drop || out_free);

    assign o_beat_pop = !i_beat_empty && (!r_s1_valid || s1_move);
    assign o_dec_pop  = s1_move && i_beat.last;

    assign o_valid  = r_o_valid;
    assign o_data   = r_o_data;
    assign o_bytes  = r_o_bytes;
    assign o_last   = r_o_last;
    assign o_status = r_o_status;

    always_ff @(posedge i_clk) begin
        if (s1_move && !drop) begin
            r_o_data   <= (strip && r_cnt == rep)
                          ? (i_dec.inner_v4 ? gtpu_pkg::ETH_IPV4 : gtpu_pkg::ETH_IPV6)
                          : i_beat.data;
            r_o_bytes  <= i_beat.odd ? 2'd1 : 2'd2;
            r_o_last   <= i_beat.last;
            r_o_status <= i_beat.last ? i_dec.status : gtpu_pkg::ST_STRIPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_beat_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_cnt <= i_beat.last ? 6'd0 : ((r_cnt == 6'd63) ? r_cnt : r_cnt + 6'd1);
            end
            if (s1_move && !drop) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/gtpu_tunnel_decapsulator_core.sv =====
`timescale 1ns / 1ps
// gtp-u decapsulator: frames enter as 16-bit beats on the input valid/ready channel
// (i_beat_data, i_beat_bytes, i_beat_last) and leave on the output channel.
// the parser classifies each beat as it arrives and stores it in a beat queue of
// HOLD_BEATS + 1 entries; a frame decision goes into a 4-entry decision queue.
// the emitter holds a frame's beats until its decision exists, then forwards,
// drops (outer ip/udp/gtp-u headers) or rewrites (ethertype) one beat per cycle
// unless the output stalls; the input takes one beat per cycle while both queues
// have room. the decision of a matching frame lands on the beat with the inner
// version nibble (beat 25 to 37); output of a frame waits for that decision, and
// each beat passes the beat queue's read register and then the output register.
// out_status carries the frame status on the last beat and is zero elsewhere.
// config writes (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) take effect at once.
// a stall at the output backs up the queues; input ready drops when either fills.
// synchronous reset empties both queues and restores the default port and type.
module gtpu_tunnel_decapsulator_core #(
    parameter int HOLD_BEATS = gtpu_pkg::HOLD_BEATS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_beat_data,
    input  logic [1:0]  i_beat_bytes,
    input  logic        i_beat_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_data,
    output logic [1:0]  o_out_bytes,
    output logic        o_out_last,
    output logic [2:0]  o_out_status
);

    logic [15:0]     r_udp_port;
    logic [7:0]      r_msg_type;

    logic            accept;
    logic            beat_push, dec_push;
    gtpu_pkg::t_beat push_beat, head_beat;
    gtpu_pkg::t_dec  push_dec, head_dec;
    logic            beat_pop, dec_pop;
    logic            beat_empty, beat_full, dec_empty, dec_full;

    assign o_in_ready = !beat_full && !dec_full;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_udp_port <= gtpu_pkg::UDP_PORT_DEF;
            r_msg_type <= gtpu_pkg::MSG_TYPE_DEF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gtpu_pkg::REG_UDP_PORT: r_udp_port <= i_cfg_wdata;
                gtpu_pkg::REG_MSG_TYPE: r_msg_type <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    gtpu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_beat_data),
        .i_bytes     (i_beat_bytes),
        .i_last      (i_beat_last),
        .i_udp_port  (r_udp_port),
        .i_msg_type  (r_msg_type),
        .o_beat_push (beat_push),
        .o_beat      (push_beat),
        .o_dec_push  (dec_push),
        .o_dec       (push_dec)
    );

    gtpu_queue #(
        .HOLD_BEATS (HOLD_BEATS)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_push  (beat_push),
        .i_beat       (push_beat),
        .i_beat_pop   (beat_pop),
        .o_beat       (head_beat),
        .o_beat_empty (beat_empty),
        .o_beat_full  (beat_full),
        .i_dec_push   (dec_push),
        .i_dec        (push_dec),
        .i_dec_pop    (dec_pop),
        .o_dec        (head_dec),
        .o_dec_empty  (dec_empty),
        .o_dec_full   (dec_full)
    );

    gtpu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (head_beat),
        .i_beat_empty (beat_empty),
        .o_beat_pop   (beat_pop),
        .i_dec        (head_dec),
        .i_dec_empty  (dec_empty),
        .o_dec_pop    (dec_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data),
        .o_bytes      (o_out_bytes),
        .o_last       (o_out_last),
        .o_status     (o_out_status)
    );

`ifndef ASSERT_OFF
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_last |-> o_out_status == gtpu_pkg::ST_STRIPPED)
        else $error("status on a non-last beat");
    a_odd_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_bytes == 2'd1 |-> o_out_last)
        else $error("odd beat before end of frame");
    a_dec_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_pop |-> !dec_empty)
        else $error("decision popped from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat_full |-> !accept)
        else $error("transaction accepted into full queue");
`endif

endmodule
